### sv/es2cd_pkg.sv
// Shared types, constants and calendar span functions for the epoch-to-date converter.
package es2cd_pkg;

   localparam logic [31:0] BASE_SECONDS   = 32'd23599380;
   localparam logic [11:0] FIRST_YEAR     = 12'd2006;
   localparam logic [3:0]  FIRST_MONTH    = 4'd1;
   localparam logic [3:0]  LAST_MONTH     = 4'd12;
   localparam logic [31:0] LEAP_YEAR_SECS = 32'd31622400;
   localparam logic [31:0] YEAR_SECS      = 32'd31536000;
   localparam logic [31:0] MONTH31_SECS   = 32'd2678400;
   localparam logic [31:0] FEB29_SECS     = 32'd2505600;
   localparam logic [31:0] FEB28_SECS     = 32'd2419200;
   localparam logic [31:0] MONTH30_SECS   = 32'd2592000;
   localparam logic [31:0] DAY_SECS       = 32'd86400;
   localparam logic [31:0] HOUR_SECS      = 32'd3600;
   localparam logic [31:0] MIN_SECS       = 32'd60;

   // Division units, taken day, then hour, then minute
   localparam logic [1:0] UNIT_DAY  = 2'd0;
   localparam logic [1:0] UNIT_HOUR = 2'd1;
   localparam logic [1:0] UNIT_MIN  = 2'd2;

   // Reciprocals for the pre-shifted remainder:
   // day (rem >> 7) / 675, hour (rem >> 4) / 225, minute (rem >> 2) / 15
   localparam logic [15:0] DAY_RECIP  = 16'd24856;
   localparam logic [4:0]  DAY_SHIFT  = 5'd24;
   localparam logic [15:0] HOUR_RECIP = 16'd4661;
   localparam logic [4:0]  HOUR_SHIFT = 5'd20;
   localparam logic [15:0] MIN_RECIP  = 16'd1093;
   localparam logic [4:0]  MIN_SHIFT  = 5'd14;

   typedef struct packed {
      logic       load;
      logic       year_step;
      logic       month_step;
      logic       div_step;
      logic       div_fix;
      logic [1:0] unit;
      logic       publish;
   } cmd_type;

   typedef struct packed {
      logic ge;
      logic month_last;
      logic invalid;
   } status_type;

   function automatic logic [31:0] month_span(input logic [3:0] month, input logic leap);
      logic [31:0] span;
      case (month) inside
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: span = MONTH31_SECS;
         4'd2:    span = leap ? FEB29_SECS : FEB28_SECS;
         default: span = MONTH30_SECS;
      endcase
      return span;
   endfunction

   function automatic logic [31:0] unit_span(input logic [1:0] unit);
      logic [31:0] base;
      case (unit)
         UNIT_DAY:  base = DAY_SECS;
         UNIT_HOUR: base = HOUR_SECS;
         default:   base = MIN_SECS;
      endcase
      return base;
   endfunction

endpackage

### sv/es2cd_ctrl.sv
// Sequencing state machine: load, year loop, month loop, constant division, result hand-off.
module es2cd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  es2cd_pkg::status_type status,
   output es2cd_pkg::cmd_type    cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_YEAR  = 3'd1;
   localparam logic [2:0] S_MONTH = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;
   localparam logic [2:0] S_FIX   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [1:0] unit_ff, unit_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in        = state_ff;
      unit_in         = unit_ff;
      cmd             = '0;
      cmd.unit        = unit_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_YEAR;
            end
         end
         S_YEAR: begin
            if (status.invalid) begin
               state_in = S_DONE;
            end else begin
               cmd.year_step = 1'b1;
               if (!status.ge) begin
                  state_in = S_MONTH;
               end
            end
         end
         S_MONTH: begin
            if (status.month_last) begin
               state_in = S_DIV;
               unit_in  = es2cd_pkg::UNIT_DAY;
            end else begin
               cmd.month_step = 1'b1;
               if (!status.ge) begin
                  state_in = S_DIV;
                  unit_in  = es2cd_pkg::UNIT_DAY;
               end
            end
         end
         S_DIV: begin
            // quotient into its counter
            cmd.div_step = 1'b1;
            state_in     = S_FIX;
         end
         S_FIX: begin
            // remainder less quotient times unit
            cmd.div_fix = 1'b1;
            case (unit_ff)
               es2cd_pkg::UNIT_DAY: begin
                  unit_in  = es2cd_pkg::UNIT_HOUR;
                  state_in = S_DIV;
               end
               es2cd_pkg::UNIT_HOUR: begin
                  unit_in  = es2cd_pkg::UNIT_MIN;
                  state_in = S_DIV;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_DONE: begin
            // output register free, or emptied by this transfer
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.publish | (rsp_valid_ff & ~rsp_ready);
   assign req_ready    = (state_ff == S_IDLE);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         unit_ff      <= es2cd_pkg::UNIT_DAY;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         unit_ff      <= unit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### sv/es2cd_dp.sv
// Datapath: remainder register, shared subtract-compare unit, date counters and result register.
module es2cd_dp (
   input  logic                  clock,
   input  logic [31:0]           req_timestamp,
   input  es2cd_pkg::cmd_type    cmd,
   output es2cd_pkg::status_type status,
   output logic                  rsp_status,
   output logic [11:0]           rsp_year,
   output logic [3:0]            rsp_month,
   output logic [4:0]            rsp_day,
   output logic [4:0]            rsp_hour,
   output logic [5:0]            rsp_minute,
   output logic [5:0]            rsp_second
);

   logic [31:0] rem_ff, rem_in;
   logic        invalid_ff, invalid_in;
   logic [11:0] year_ff, year_in;
   logic [3:0]  month_ff, month_in;
   logic [4:0]  dayq_ff, dayq_in;
   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  min_ff, min_in;
   logic [31:0] span;
   logic [32:0] diff;
   logic [32:0] base_diff;
   logic        ge;

   logic [15:0] mul_a;
   logic [15:0] mul_b;
   logic [4:0]  recip_shift;
   logic [31:0] mul_p;
   logic [5:0]  quot;
   logic [5:0]  quot_held;
   logic [31:0] quot_secs;

   logic        rsp_status_ff;
   logic [11:0] rsp_year_ff;
   logic [3:0]  rsp_month_ff;
   logic [4:0]  rsp_day_ff;
   logic [4:0]  rsp_hour_ff;
   logic [5:0]  rsp_minute_ff;
   logic [5:0]  rsp_second_ff;

   // quotient by reciprocal multiplication; remainder below 31 days, 1 day, 1 hour
   always_comb begin
      case (cmd.unit)
         es2cd_pkg::UNIT_DAY: begin
            mul_a       = {1'b0, rem_ff[21:7]};
            mul_b       = es2cd_pkg::DAY_RECIP;
            recip_shift = es2cd_pkg::DAY_SHIFT;
         end
         es2cd_pkg::UNIT_HOUR: begin
            mul_a       = {3'b000, rem_ff[16:4]};
            mul_b       = es2cd_pkg::HOUR_RECIP;
            recip_shift = es2cd_pkg::HOUR_SHIFT;
         end
         default: begin
            mul_a       = {6'b000000, rem_ff[11:2]};
            mul_b       = es2cd_pkg::MIN_RECIP;
            recip_shift = es2cd_pkg::MIN_SHIFT;
         end
      endcase
   end

   assign mul_p = {16'd0, mul_a} * {16'd0, mul_b};
   assign quot  = 6'(mul_p >> recip_shift);

   always_comb begin
      case (cmd.unit)
         es2cd_pkg::UNIT_DAY:  quot_held = {1'b0, dayq_ff};
         es2cd_pkg::UNIT_HOUR: quot_held = {1'b0, hour_ff};
         default:              quot_held = min_ff;
      endcase
   end

   assign quot_secs = {26'd0, quot_held} * es2cd_pkg::unit_span(cmd.unit);

   always_comb begin
      if (cmd.year_step) begin
         span = (year_ff[1:0] == 2'b00) ? es2cd_pkg::LEAP_YEAR_SECS : es2cd_pkg::YEAR_SECS;
      end else if (cmd.month_step) begin
         span = es2cd_pkg::month_span(month_ff, year_ff[1:0] == 2'b00);
      end else begin
         span = quot_secs;
      end
   end

   assign diff      = {1'b0, rem_ff} - {1'b0, span};
   assign ge        = ~diff[32];
   assign base_diff = {1'b0, req_timestamp} - {1'b0, es2cd_pkg::BASE_SECONDS};

   assign status.ge         = ge;
   assign status.month_last = (month_ff == es2cd_pkg::LAST_MONTH);
   assign status.invalid    = invalid_ff;

   always_comb begin
      rem_in     = rem_ff;
      invalid_in = invalid_ff;
      year_in    = year_ff;
      month_in   = month_ff;
      dayq_in    = dayq_ff;
      hour_in    = hour_ff;
      min_in     = min_ff;
      if (cmd.load) begin
         rem_in     = base_diff[31:0];
         invalid_in = base_diff[32];
         year_in    = es2cd_pkg::FIRST_YEAR;
         month_in   = es2cd_pkg::FIRST_MONTH;
         dayq_in    = '0;
         hour_in    = '0;
         min_in     = '0;
      end else if (cmd.div_step) begin
         case (cmd.unit)
            es2cd_pkg::UNIT_DAY:  dayq_in = quot[4:0];
            es2cd_pkg::UNIT_HOUR: hour_in = quot[4:0];
            default:              min_in  = quot;
         endcase
      end else if (ge && (cmd.year_step || cmd.month_step || cmd.div_fix)) begin
         rem_in = diff[31:0];
         if (cmd.year_step) begin
            year_in = year_ff + 12'd1;
         end else if (cmd.month_step) begin
            month_in = month_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      invalid_ff <= invalid_in;
      year_ff    <= year_in;
      month_ff   <= month_in;
      dayq_ff    <= dayq_in;
      hour_ff    <= hour_in;
      min_ff     <= min_in;
      if (cmd.publish) begin
         rsp_status_ff <= invalid_ff;
         if (invalid_ff) begin
            rsp_year_ff   <= '0;
            rsp_month_ff  <= '0;
            rsp_day_ff    <= '0;
            rsp_hour_ff   <= '0;
            rsp_minute_ff <= '0;
            rsp_second_ff <= '0;
         end else begin
            rsp_year_ff   <= year_ff;
            rsp_month_ff  <= month_ff;
            rsp_day_ff    <= dayq_ff + 5'd1;
            rsp_hour_ff   <= hour_ff;
            rsp_minute_ff <= min_ff;
            rsp_second_ff <= rem_ff[5:0];
         end
      end
   end

   assign rsp_status = rsp_status_ff;
   assign rsp_year   = rsp_year_ff;
   assign rsp_month  = rsp_month_ff;
   assign rsp_day    = rsp_day_ff;
   assign rsp_hour   = rsp_hour_ff;
   assign rsp_minute = rsp_minute_ff;
   assign rsp_second = rsp_second_ff;

endmodule

### sv/epoch_seconds_to_calendar_date_top.sv
// Sequence: load, year steps, month steps, then quotient and fix steps for day, hour and
// minute, then hand-off; a timestamp below base goes from the year state straight to hand-off.
// Throughput: one item at a time; set by the year loop through the single subtract unit.
// The result register lets the next item be taken while a result still waits.
// Reset (synchronous, active high) clears the sequencer and result valid; ready is high after.
module epoch_seconds_to_calendar_date_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_timestamp,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_status,
   output logic [11:0] rsp_year,
   output logic [3:0]  rsp_month,
   output logic [4:0]  rsp_day,
   output logic [4:0]  rsp_hour,
   output logic [5:0]  rsp_minute,
   output logic [5:0]  rsp_second
);

   es2cd_pkg::cmd_type    cmd;
   es2cd_pkg::status_type status;

   es2cd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   es2cd_dp u_dp (
      .clock         (clock),
      .req_timestamp (req_timestamp),
      .cmd           (cmd),
      .status        (status),
      .rsp_status    (rsp_status),
      .rsp_year      (rsp_year),
      .rsp_month     (rsp_month),
      .rsp_day       (rsp_day),
      .rsp_hour      (rsp_hour),
      .rsp_minute    (rsp_minute),
      .rsp_second    (rsp_second)
   );

endmodule

### sv/es2cd_chk.sv
// Port-level checker for the epoch-to-date converter, bound to the top level.
module es2cd_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [31:0] req_timestamp,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_status,
   input logic [11:0] rsp_year,
   input logic [3:0]  rsp_month,
   input logic [4:0]  rsp_day,
   input logic [4:0]  rsp_hour,
   input logic [5:0]  rsp_minute,
   input logic [5:0]  rsp_second
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // one item in flight: no back-to-back input transfers
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while previous item busy");

   // an input below base reports invalid with zeroed fields
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_year == 12'd0 && rsp_month == 4'd0 && rsp_day == 5'd0
         && rsp_hour == 5'd0 && rsp_minute == 6'd0 && rsp_second == 6'd0)
      else $error("invalid result carries non-zero fields");

   a_valid_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_status |-> rsp_year >= 12'd2006 && rsp_month >= 4'd1
         && rsp_month <= 4'd12 && rsp_day >= 5'd1 && rsp_hour <= 5'd23
         && rsp_minute <= 6'd59 && rsp_second <= 6'd59)
      else $error("date field out of range");

endmodule

bind epoch_seconds_to_calendar_date_top es2cd_chk u_es2cd_chk (.*);

### sim/epoch_seconds_to_calendar_date_top_tb.sv
// Self-checking testbench for the epoch-seconds to calendar-date converter.
`timescale 1ns / 100ps

module epoch_seconds_to_calendar_date_top_tb;

   localparam logic [31:0] EPOCH_2006      = 32'd23599380;
   localparam logic [31:0] LEAP_YEAR_LEN   = 32'd31622400;
   localparam logic [31:0] COMMON_YEAR_LEN = 32'd31536000;
   localparam logic [31:0] LONG_MONTH_LEN  = 32'd2678400;
   localparam logic [31:0] FEB_LEAP_LEN    = 32'd2505600;
   localparam logic [31:0] FEB_COMMON_LEN  = 32'd2419200;
   localparam logic [31:0] SHORT_MONTH_LEN = 32'd2592000;
   localparam logic [31:0] SECS_PER_DAY    = 32'd86400;
   localparam logic [31:0] SECS_PER_HOUR   = 32'd3600;
   localparam logic [31:0] SECS_PER_MIN    = 32'd60;
   localparam int          FIRST_YEAR      = 2006;
   localparam int          LAST_FULL_YEAR  = 2140;
   localparam logic        STATUS_OK       = 1'b0;
   localparam logic        STATUS_INVALID  = 1'b1;
   localparam int          IDLE_PERCENT    = 11;
   localparam int          DRAIN_CYCLES    = 200;

   typedef struct packed {
      logic        status;
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } calendar_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_timestamp = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_status;
   logic [11:0] rsp_year;
   logic [3:0]  rsp_month;
   logic [4:0]  rsp_day;
   logic [4:0]  rsp_hour;
   logic [5:0]  rsp_minute;
   logic [5:0]  rsp_second;

   calendar_type pending_dates[$];
   int        mismatches = 0;
   int        sent_count = 0;
   int        invalid_count = 0;
   int        checked_count = 0;
   bit        no_idling = 1'b0;

   epoch_seconds_to_calendar_date_top DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_timestamp (req_timestamp),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_year      (rsp_year),
      .rsp_month     (rsp_month),
      .rsp_day       (rsp_day),
      .rsp_hour      (rsp_hour),
      .rsp_minute    (rsp_minute),
      .rsp_second    (rsp_second)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("[epoch_seconds_to_calendar_date_top] ERROR");
      $finish;
   end

   // ------------------------------------------------------------------
   // Calendar arithmetic
   // ------------------------------------------------------------------
   function automatic logic [31:0] year_length(input int yr);
      // two low bits clear means leap, 2100 included
      return (yr[1:0] == 2'b00) ? LEAP_YEAR_LEN : COMMON_YEAR_LEN;
   endfunction

   function automatic logic [31:0] month_length(input int mo, input int yr);
      logic [31:0] len;
      case (mo)
         1, 3, 5, 7, 8, 10, 12: len = LONG_MONTH_LEN;
         2:       len = (yr[1:0] == 2'b00) ? FEB_LEAP_LEN : FEB_COMMON_LEN;
         default: len = SHORT_MONTH_LEN;
      endcase
      return len;
   endfunction

   function automatic calendar_type to_calendar(input logic [31:0] ts);
      calendar_type c;
      logic [31:0] rest;
      int          yr;
      int          mo;
      c = '0;
      if (ts < EPOCH_2006) begin
         c.status = STATUS_INVALID;
         return c;
      end
      rest = ts - EPOCH_2006;
      yr = FIRST_YEAR;
      while (rest >= year_length(yr)) begin
         rest -= year_length(yr);
         yr++;
      end
      mo = 1;
      while (mo < 12 && rest >= month_length(mo, yr)) begin
         rest -= month_length(mo, yr);
         mo++;
      end
      c.status = STATUS_OK;
      c.year   = 12'(yr);
      c.month  = 4'(mo);
      c.day    = 5'(1 + rest / SECS_PER_DAY);
      rest     = rest % SECS_PER_DAY;
      c.hour   = 5'(rest / SECS_PER_HOUR);
      rest     = rest % SECS_PER_HOUR;
      c.minute = 6'(rest / SECS_PER_MIN);
      c.second = 6'(rest % SECS_PER_MIN);
      return c;
   endfunction

   // First second of the given month, 64 bits wide so late dates can be range checked
   function automatic logic [63:0] month_start(input int yr, input int mo);
      logic [63:0] t;
      t = 64'(EPOCH_2006);
      for (int y = FIRST_YEAR; y < yr; y++) t += 64'(year_length(y));
      for (int m = 1; m < mo; m++) t += 64'(month_length(m, yr));
      return t;
   endfunction

   // ------------------------------------------------------------------
   // Transfer handling
   // ------------------------------------------------------------------
   task automatic send_timestamp(input logic [31:0] ts);
      while (!no_idling && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_timestamp <= ts;
      do @(posedge clock); while (!req_ready);
      pending_dates.push_back(to_calendar(ts));
      sent_count++;
      if (ts < EPOCH_2006) invalid_count++;
   endtask

   // Hold the request side off until every outstanding date has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_dates.size() != 0);
   endtask

   always @(posedge clock) begin
      rsp_ready <= no_idling || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      calendar_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_dates.size() == 0) begin
            mismatches++;
            $display("%0t: result transfer with nothing outstanding", $realtime);
         end else begin
            want = pending_dates.pop_front();
            checked_count++;
            compare_field("status", int'(want.status), int'(rsp_status));
            compare_field("year",   int'(want.year),   int'(rsp_year));
            compare_field("month",  int'(want.month),  int'(rsp_month));
            compare_field("day",    int'(want.day),    int'(rsp_day));
            compare_field("hour",   int'(want.hour),   int'(rsp_hour));
            compare_field("minute", int'(want.minute), int'(rsp_minute));
            compare_field("second", int'(want.second), int'(rsp_second));
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   function automatic logic [31:0] pick_timestamp();
      int          kind;
      logic [63:0] t;
      kind = $urandom_range(0, 99);
      if (kind < 8) return $urandom_range(0, EPOCH_2006 - 1);
      if (kind < 40) begin
         // one second either side of a month, day or hour edge
         t = month_start($urandom_range(FIRST_YEAR, LAST_FULL_YEAR), $urandom_range(1, 12));
         if ($urandom_range(0, 1)) t += 64'($urandom_range(0, 27)) * SECS_PER_DAY;
         if ($urandom_range(0, 1)) t += 64'($urandom_range(0, 23)) * SECS_PER_HOUR;
         t = t - 1 + $urandom_range(0, 2);
         if (t <= 64'hFFFF_FFFF) return t[31:0];
      end
      return $urandom();
   endfunction

   task automatic test_field_extremes();
      send_timestamp(32'd0);
      send_timestamp(32'd1);
      send_timestamp(EPOCH_2006 - 1);
      send_timestamp(EPOCH_2006);
      send_timestamp(EPOCH_2006 + 1);
      send_timestamp(32'h7FFF_FFFF);
      send_timestamp(32'h8000_0000);
      send_timestamp(32'h5555_5555);
      send_timestamp(32'hAAAA_AAAA);
      send_timestamp(32'hFFFF_FFFE);
      send_timestamp(32'hFFFF_FFFF);
   endtask

   task automatic test_calendar_edges();
      send_timestamp(EPOCH_2006 + SECS_PER_MIN - 1);
      send_timestamp(EPOCH_2006 + SECS_PER_HOUR - 1);
      send_timestamp(EPOCH_2006 + SECS_PER_DAY - 1);
      send_timestamp(32'(month_start(2006, 2) - 1));
      send_timestamp(32'(month_start(2007, 1) - 1));   // last second of a common year
      send_timestamp(32'(month_start(2007, 3) - 1));   // 28 February
      send_timestamp(32'(month_start(2008, 3) - 1));   // 29 February
      send_timestamp(32'(month_start(2008, 3)));
      send_timestamp(32'(month_start(2100, 3) - 1));   // 2100 still treated as leap
      send_timestamp(32'(month_start(LAST_FULL_YEAR, 12)));
   endtask

   task automatic test_back_to_back(input int count);
      no_idling = 1'b1;
      repeat (count) send_timestamp(pick_timestamp());
      wait_for_results();
      no_idling = 1'b0;
   endtask

   task automatic test_random_with_stalls(input int count);
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) wait_for_results();
         send_timestamp(pick_timestamp());
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_field_extremes();
      test_calendar_edges();
      test_back_to_back(200);
      test_random_with_stalls(630);
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_dates.size() != 0) begin
         mismatches++;
         $display("%0t: %0d dates never returned", $realtime, pending_dates.size());
      end
      $display("Converted %0d timestamps (%0d below the 2006 epoch), %0d results checked,",
               sent_count, invalid_count, checked_count);
      $display("covering word extremes, leap and month edges, back-to-back and stalled traffic.");
      if (mismatches == 0) begin
         $display("[epoch_seconds_to_calendar_date_top] OK");
      end else begin
         $display("[epoch_seconds_to_calendar_date_top] ERROR");
      end
      $finish;
   end

endmodule
